[hdl/mcc_pkg.sv]
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared widths, register indexes, types and rounding helpers for the
// magnetometer calibration datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

    localparam int MAG_W     = 24;
    localparam int SCL_W     = 16;
    localparam int ANG_W     = 16;
    localparam int SKEW_W    = 48;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;

    localparam int FRAC_SHIFT = 14;
    localparam int DIFF_W     = MAG_W + 1;
    localparam int DIV_NUM_W  = DIFF_W + FRAC_SHIFT;
    localparam int DIV_STEPS  = DIV_NUM_W;
    localparam int QMAG_W     = MAG_W + 1;
    localparam int QUO_W      = QMAG_W + 1;
    localparam int PROD_W     = ANG_W + MAG_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int RND_W      = ACC_W - 15;
    localparam int SUM_W      = 28;

    localparam logic [SCL_W-1:0] SCALE_ONE = SCL_W'(16384);
    localparam logic signed [MAG_W-1:0] CAL_MAX = 24'sh7FFFFF;
    localparam logic signed [MAG_W-1:0] CAL_MIN = -24'sh800000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_X = 3'd0,
        REG_SCALE_Y = 3'd1,
        REG_SCALE_Z = 3'd2,
        REG_BIAS_X  = 3'd3,
        REG_BIAS_Y  = 3'd4,
        REG_BIAS_Z  = 3'd5,
        REG_SKEW    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic x;
        logic y;
        logic z;
    } t_zero_ctl;

    typedef struct packed {
        logic signed [ANG_W-1:0] lam;
        logic signed [ANG_W-1:0] phi;
        logic signed [ANG_W-1:0] rho;
    } t_skew;

    // v / 2^15, nearest, ties away from zero
    function automatic logic signed [RND_W-1:0] rnd15(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] q;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        q   = (mag + ACC_W'(16384)) >> 15;
        return v[ACC_W-1] ? -$signed(q[RND_W-1:0]) : $signed(q[RND_W-1:0]);
    endfunction

    // clip bit on top, value below
    function automatic logic [MAG_W:0] sat24(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(CAL_MAX)) begin
            return {1'b1, CAL_MAX};
        end else if (v < SUM_W'(CAL_MIN)) begin
            return {1'b1, CAL_MIN};
        end
        return {1'b0, v[MAG_W-1:0]};
    endfunction

endpackage

`default_nettype wire

[hdl/mcc_in_if.sv]
// ----------------------------------------------------------------------------
// mcc_in_if
// Sample channel: one three-axis raw field reading per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcc_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [23:0]       mag_x;
    logic signed [23:0]       mag_y;
    logic signed [23:0]       mag_z;

    modport source (output valid, output mag_x, output mag_y, output mag_z, input ready);
    modport sink   (input valid, input mag_x, input mag_y, input mag_z, output ready);
endinterface

`default_nettype wire

[hdl/mcc_out_if.sv]
// ----------------------------------------------------------------------------
// mcc_out_if
// Result channel: corrected field and status flags per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcc_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] cal_x;
    logic signed [23:0] cal_y;
    logic signed [23:0] cal_z;
    logic               default_params;
    logic               saturated;
    logic               zero_scale;

    modport source (output valid, output cal_x, output cal_y, output cal_z,
                    output default_params, output saturated, output zero_scale,
                    input ready);
    modport sink   (input valid, input cal_x, input cal_y, input cal_z,
                    input default_params, input saturated, input zero_scale,
                    output ready);
endinterface

`default_nettype wire

[hdl/mcc_div.sv]
// ----------------------------------------------------------------------------
// mcc_div
// One axis: bias removal and pipelined restoring division of the offset
// magnitude (scaled by 2^14, half divisor added for rounding) by the scale.
// One quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_div (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic signed [mcc_pkg::MAG_W-1:0]      i_mag,
    input  wire logic signed [mcc_pkg::MAG_W-1:0]      i_bias,
    input  wire logic        [mcc_pkg::SCL_W-1:0]      i_scale,
    output logic signed      [mcc_pkg::QUO_W-1:0]      o_quot,
    output logic                                       o_neg
);
    import mcc_pkg::*;

    logic [SCL_W-1:0]     r_rem [0:DIV_STEPS];
    logic [DIV_NUM_W-1:0] r_num [0:DIV_STEPS];
    logic                 r_neg [0:DIV_STEPS];

    logic signed [DIFF_W-1:0] diff;
    logic        [DIFF_W-1:0] dmag;
    logic    [DIV_NUM_W-1:0]  num0;
    logic         [QMAG_W-1:0] qmag;
    logic     [DIV_NUM_W-1:0] quo;

    always_comb begin
        diff = {i_mag[MAG_W-1], i_mag} - {i_bias[MAG_W-1], i_bias};
        dmag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        num0 = {dmag, FRAC_SHIFT'(0)} + DIV_NUM_W'(i_scale >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_num[0] <= num0;
            r_neg[0] <= diff[DIFF_W-1];
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [SCL_W:0] w_trial;
        logic           w_ge;
        always_comb begin
            w_trial = {r_rem[k], r_num[k][DIV_NUM_W-1]};
            w_ge    = w_trial >= {1'b0, i_scale};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_ge ? SCL_W'(w_trial - {1'b0, i_scale}) : w_trial[SCL_W-1:0];
                r_num[k+1] <= {r_num[k][DIV_NUM_W-2:0], w_ge};
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    // large quotients only need to stay large enough to saturate downstream
    always_comb begin
        quo  = r_num[DIV_STEPS];
        qmag = (|quo[DIV_NUM_W-1:QMAG_W]) ? {QMAG_W{1'b1}} : quo[QMAG_W-1:0];
        o_quot = r_neg[DIV_STEPS] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
        o_neg  = r_neg[DIV_STEPS];
    end

endmodule

`default_nettype wire

[hdl/mcc_skew.sv]
// ----------------------------------------------------------------------------
// mcc_skew
// Non-orthogonality stages: saturate x, remove rho*x from y, then
// lam*x + phi*y from z. Products are registered before rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_skew (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_en,
    input  wire logic                                 i_valid,
    input  wire logic signed [mcc_pkg::QUO_W-1:0]     i_qx,
    input  wire logic signed [mcc_pkg::QUO_W-1:0]     i_qy,
    input  wire logic signed [mcc_pkg::QUO_W-1:0]     i_qz,
    input  wire mcc_pkg::t_zero_ctl                   i_neg,
    input  wire mcc_pkg::t_zero_ctl                   i_zero,
    input  wire mcc_pkg::t_skew                       i_skew,
    output logic                                      o_valid,
    output logic signed [mcc_pkg::MAG_W-1:0]          o_cx,
    output logic signed [mcc_pkg::MAG_W-1:0]          o_cy,
    output logic signed [mcc_pkg::MAG_W-1:0]          o_cz,
    output logic                                      o_clip
);
    import mcc_pkg::*;

    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic r1_clip, r2_clip, r3_clip, r4_clip, r5_clip;
    logic r1_ny, r2_ny, r1_nz, r2_nz, r3_nz, r4_nz;
    logic signed [MAG_W-1:0]  r1_cx, r2_cx, r3_cx, r4_cx, r3_cy, r4_cy;
    logic signed [MAG_W-1:0]  r5_cx, r5_cy, r5_cz;
    logic signed [QUO_W-1:0]  r1_qy, r2_qy, r1_qz, r2_qz, r3_qz, r4_qz;
    logic signed [PROD_W-1:0] r2_py, r4_pl, r4_pp;

    logic [MAG_W:0]            n1_x, n3_y, n5_z;
    logic signed [ACC_W-1:0]   acc_z;

    always_comb begin
        n1_x = sat24(SUM_W'(i_qx));
        if (i_zero.x) begin
            n1_x = {1'b1, i_neg.x ? CAL_MIN : CAL_MAX};
        end
        n3_y = sat24(SUM_W'(r2_qy) - SUM_W'(rnd15(ACC_W'(r2_py))));
        if (i_zero.y) begin
            n3_y = {1'b1, r2_ny ? CAL_MIN : CAL_MAX};
        end
        acc_z = ACC_W'(r4_pl) + ACC_W'(r4_pp);
        n5_z  = sat24(SUM_W'(r4_qz) - SUM_W'(rnd15(acc_z)));
        if (i_zero.z) begin
            n5_z = {1'b1, r4_nz ? CAL_MIN : CAL_MAX};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cx   <= n1_x[MAG_W-1:0];
            r1_clip <= n1_x[MAG_W];
            r1_qy   <= i_qy;
            r1_qz   <= i_qz;
            r1_ny   <= i_neg.y;
            r1_nz   <= i_neg.z;

            r2_py   <= i_skew.rho * r1_cx;
            r2_cx   <= r1_cx;
            r2_qy   <= r1_qy;
            r2_qz   <= r1_qz;
            r2_ny   <= r1_ny;
            r2_nz   <= r1_nz;
            r2_clip <= r1_clip;

            r3_cx   <= r2_cx;
            r3_cy   <= n3_y[MAG_W-1:0];
            r3_clip <= r2_clip | n3_y[MAG_W];
            r3_qz   <= r2_qz;
            r3_nz   <= r2_nz;

            r4_pl   <= i_skew.lam * r3_cx;
            r4_pp   <= i_skew.phi * r3_cy;
            r4_cx   <= r3_cx;
            r4_cy   <= r3_cy;
            r4_qz   <= r3_qz;
            r4_nz   <= r3_nz;
            r4_clip <= r3_clip;

            r5_cx   <= r4_cx;
            r5_cy   <= r4_cy;
            r5_cz   <= n5_z[MAG_W-1:0];
            r5_clip <= r4_clip | n5_z[MAG_W];
        end
    end

    assign o_valid = r5_vld;
    assign o_cx    = r5_cx;
    assign o_cy    = r5_cy;
    assign o_cz    = r5_cz;
    assign o_clip  = r5_clip;

endmodule

`default_nettype wire

[hdl/magnetometer_calibration_correct.sv]
// ----------------------------------------------------------------------------
// magnetometer_calibration_correct
// Bias, scale and non-orthogonality correction of three-axis samples.
//
// i_in carries raw samples, o_out the corrected field with flags. Registers
// are written through i_cfg_we / i_cfg_idx / i_cfg_data, which the user must
// use only while no sample is in flight; the block does not enforce this.
// One sample is taken every cycle while the receiver does not stall. The
// pipeline is the bit-per-stage dividers (40 stages including the offset
// stage) followed by five stages for saturation and the skew products.
// When o_out is held not ready with a result waiting, the whole pipeline
// freezes and i_in.ready drops; nothing is lost or repeated. Reset empties
// the pipeline and loads unit scales, zero biases and zero angles, under
// which samples pass through unchanged with default_params set.
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_calibration_correct (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    mcc_in_if.sink                                i_in,
    mcc_out_if.source                             o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [mcc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mcc_pkg::CFG_W-1:0]        i_cfg_data
);
    import mcc_pkg::*;

    logic [SCL_W-1:0]  r_scale_x, r_scale_y, r_scale_z;
    logic [MAG_W-1:0]  r_bias_x, r_bias_y, r_bias_z;
    logic [SKEW_W-1:0] r_skew;
    logic              r_vld [0:DIV_STEPS];

    logic                     en;
    logic signed [QUO_W-1:0]  qx, qy, qz;
    t_zero_ctl                negs, zeros;
    t_skew                    skew;
    logic                     sk_valid, sk_clip, dflt;
    logic signed [MAG_W-1:0]  cx, cy, cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= SCALE_ONE;
            r_scale_y <= SCALE_ONE;
            r_scale_z <= SCALE_ONE;
            r_bias_x  <= '0;
            r_bias_y  <= '0;
            r_bias_z  <= '0;
            r_skew    <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SCALE_X: r_scale_x <= i_cfg_data[SCL_W-1:0];
                REG_SCALE_Y: r_scale_y <= i_cfg_data[SCL_W-1:0];
                REG_SCALE_Z: r_scale_z <= i_cfg_data[SCL_W-1:0];
                REG_BIAS_X:  r_bias_x  <= i_cfg_data[MAG_W-1:0];
                REG_BIAS_Y:  r_bias_y  <= i_cfg_data[MAG_W-1:0];
                REG_BIAS_Z:  r_bias_z  <= i_cfg_data[MAG_W-1:0];
                REG_SKEW:    r_skew    <= i_cfg_data[SKEW_W-1:0];
                default: ;
            endcase
        end
    end

    // global stall: every stage advances only when the output can move
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    mcc_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mag  (i_in.mag_x),
        .i_bias (r_bias_x),
        .i_scale(r_scale_x),
        .o_quot (qx),
        .o_neg  (negs.x)
    );

    mcc_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mag  (i_in.mag_y),
        .i_bias (r_bias_y),
        .i_scale(r_scale_y),
        .o_quot (qy),
        .o_neg  (negs.y)
    );

    mcc_div u_div_z (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mag  (i_in.mag_z),
        .i_bias (r_bias_z),
        .i_scale(r_scale_z),
        .o_quot (qz),
        .o_neg  (negs.z)
    );

    always_comb begin
        zeros.x  = r_scale_x == '0;
        zeros.y  = r_scale_y == '0;
        zeros.z  = r_scale_z == '0;
        skew.rho = r_skew[ANG_W-1:0];
        skew.phi = r_skew[2*ANG_W-1:ANG_W];
        skew.lam = r_skew[3*ANG_W-1:2*ANG_W];
        // unit scales divide exactly, so defaults need only the flag
        dflt = r_scale_x == SCALE_ONE && r_scale_y == SCALE_ONE &&
               r_scale_z == SCALE_ONE && r_bias_x == '0 && r_bias_y == '0 &&
               r_bias_z == '0 && r_skew == '0;
    end

    mcc_skew u_skew (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_vld[DIV_STEPS]),
        .i_qx   (qx),
        .i_qy   (qy),
        .i_qz   (qz),
        .i_neg  (negs),
        .i_zero (zeros),
        .i_skew (skew),
        .o_valid(sk_valid),
        .o_cx   (cx),
        .o_cy   (cy),
        .o_cz   (cz),
        .o_clip (sk_clip)
    );

    assign o_out.valid          = sk_valid;
    assign o_out.cal_x          = cx;
    assign o_out.cal_y          = cy;
    assign o_out.cal_z          = cz;
    assign o_out.saturated      = sk_clip;
    assign o_out.default_params = dflt;
    assign o_out.zero_scale     = zeros.x | zeros.y | zeros.z;

    a_dflt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.default_params |-> !o_out.saturated && !o_out.zero_scale)
        else $error("default parameters with clip or zero scale");

    a_zero_clips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_scale |-> o_out.saturated)
        else $error("zero scale without saturation flag");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

[verif/mcc_checker.sv]
// ----------------------------------------------------------------------------
// mcc_checker
// Watches the sample and result channels, computes the corrected field for
// each accepted sample from its own register shadow and compares every
// result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcc_checker
    import mcc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    mcc_in_if.sink                 i_in,
    mcc_out_if.sink                i_out,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    output int                     o_fail_cnt,
    output int                     o_pending,
    output int                     o_result_cnt
);

    typedef struct packed {
        logic signed [23:0] cal_x;
        logic signed [23:0] cal_y;
        logic signed [23:0] cal_z;
        logic               dflt;
        logic               sat;
        logic               zs;
    } t_cal;

    t_cal cal_q[$];

    logic [15:0] sh_scale_x, sh_scale_y, sh_scale_z;
    logic [23:0] sh_bias_x, sh_bias_y, sh_bias_z;
    logic [47:0] sh_skew;

    // (diff * 2^14) / scale, nearest, ties away from zero
    function automatic longint div_near(longint diff, longint scale);
        longint m;
        longint q;
        m = diff < 0 ? -diff : diff;
        q = ((m <<< 14) + (scale >>> 1)) / scale;
        return diff < 0 ? -q : q;
    endfunction

    function automatic longint round15(longint v);
        longint m;
        longint q;
        m = v < 0 ? -v : v;
        q = (m + 16384) >>> 15;
        return v < 0 ? -q : q;
    endfunction

    function automatic longint clip24(longint v, ref bit clip);
        if (v > 8388607) begin
            clip = 1;
            return 8388607;
        end
        if (v < -8388608) begin
            clip = 1;
            return -8388608;
        end
        return v;
    endfunction

    function automatic t_cal correct_field(logic signed [23:0] mx, logic signed [23:0] my,
                                           logic signed [23:0] mz);
        t_cal r;
        longint bx, by, bz, rho, phi, lam, cx, cy, cz, d;
        bit clip;
        bit zs;
        bit dflt;
        bx = longint'($signed(sh_bias_x));
        by = longint'($signed(sh_bias_y));
        bz = longint'($signed(sh_bias_z));
        rho = longint'($signed(sh_skew[15:0]));
        phi = longint'($signed(sh_skew[31:16]));
        lam = longint'($signed(sh_skew[47:32]));
        clip = 0;
        zs = 0;
        dflt = sh_scale_x == SCALE_ONE && sh_scale_y == SCALE_ONE && sh_scale_z == SCALE_ONE
               && bx == 0 && by == 0 && bz == 0 && sh_skew == 0;
        if (dflt) begin
            cx = mx;
            cy = my;
            cz = mz;
        end else begin
            d = longint'(mx) - bx;
            if (sh_scale_x == 0) begin
                zs = 1; clip = 1; cx = d >= 0 ? 8388607 : -8388608;
            end else begin
                cx = clip24(div_near(d, sh_scale_x), clip);
            end
            d = longint'(my) - by;
            if (sh_scale_y == 0) begin
                zs = 1; clip = 1; cy = d >= 0 ? 8388607 : -8388608;
            end else begin
                cy = clip24(div_near(d, sh_scale_y) - round15(rho * cx), clip);
            end
            d = longint'(mz) - bz;
            if (sh_scale_z == 0) begin
                zs = 1; clip = 1; cz = d >= 0 ? 8388607 : -8388608;
            end else begin
                cz = clip24(div_near(d, sh_scale_z) - round15(lam * cx + phi * cy), clip);
            end
        end
        r.cal_x = cx[23:0];
        r.cal_y = cy[23:0];
        r.cal_z = cz[23:0];
        r.dflt = dflt;
        r.sat = clip;
        r.zs = zs;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        o_fail_cnt++;
    endtask

    assign o_pending = cal_q.size();

    initial begin
        o_fail_cnt = 0;
        o_result_cnt = 0;
    end

    always @(posedge i_clk) begin
        t_cal e;
        if (!i_rst_n) begin
            sh_scale_x <= SCALE_ONE;
            sh_scale_y <= SCALE_ONE;
            sh_scale_z <= SCALE_ONE;
            sh_bias_x <= '0;
            sh_bias_y <= '0;
            sh_bias_z <= '0;
            sh_skew <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_SCALE_X: sh_scale_x <= i_cfg_data[15:0];
                    REG_SCALE_Y: sh_scale_y <= i_cfg_data[15:0];
                    REG_SCALE_Z: sh_scale_z <= i_cfg_data[15:0];
                    REG_BIAS_X:  sh_bias_x <= i_cfg_data[23:0];
                    REG_BIAS_Y:  sh_bias_y <= i_cfg_data[23:0];
                    REG_BIAS_Z:  sh_bias_z <= i_cfg_data[23:0];
                    REG_SKEW:    sh_skew <= i_cfg_data[47:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                cal_q.push_back(correct_field(i_in.mag_x, i_in.mag_y, i_in.mag_z));
            end
            if (i_out.valid && i_out.ready) begin
                o_result_cnt++;
                if (cal_q.size() == 0) begin
                    report_mismatch("unexpected result, cal_x", i_out.cal_x, 0);
                end else begin
                    e = cal_q.pop_front();
                    if (i_out.cal_x !== e.cal_x) report_mismatch("cal_x", i_out.cal_x, e.cal_x);
                    if (i_out.cal_y !== e.cal_y) report_mismatch("cal_y", i_out.cal_y, e.cal_y);
                    if (i_out.cal_z !== e.cal_z) report_mismatch("cal_z", i_out.cal_z, e.cal_z);
                    if (i_out.default_params !== e.dflt)
                        report_mismatch("default_params", i_out.default_params, e.dflt);
                    if (i_out.saturated !== e.sat)
                        report_mismatch("saturated", i_out.saturated, e.sat);
                    if (i_out.zero_scale !== e.zs)
                        report_mismatch("zero_scale", i_out.zero_scale, e.zs);
                end
            end
        end
    end

endmodule

[verif/magnetometer_calibration_correct_tb.sv]
// ----------------------------------------------------------------------------
// magnetometer_calibration_correct_tb
// Drives samples through several register settings with random gaps and
// receiver stalls, one long stall included; the checker judges each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module magnetometer_calibration_correct_tb;
    import mcc_pkg::*;

    localparam int LIMIT = 400000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    int fail_cnt, pending, result_cnt;
    int cycle_cnt = 0;
    bit long_hold = 0;
    int sent_cnt = 0;

    mcc_in_if  in_ch();
    mcc_out_if out_ch();

    initial begin
        in_ch.valid = 0;
        in_ch.mag_x = '0;
        in_ch.mag_y = '0;
        in_ch.mag_z = '0;
        out_ch.ready = 0;
    end

    always #2 i_clk = ~i_clk;

    magnetometer_calibration_correct dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    mcc_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .i_out(out_ch.sink),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_result_cnt(result_cnt)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("magnetometer_calibration_correct: mismatch");
            $finish;
        end
    end

    // receiver: random gap per result, plus one long hold-off
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                out_ch.ready <= 0;
                repeat (200) @(posedge i_clk);
                long_hold = 0;
            end
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                out_ch.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1;
            @(posedge i_clk iff out_ch.valid);
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 0;
    endtask

    task automatic send_sample(logic [23:0] x, logic [23:0] y, logic [23:0] z, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.mag_x <= x;
        in_ch.mag_y <= y;
        in_ch.mag_z <= z;
        @(posedge i_clk iff in_ch.ready);
        sent_cnt++;
    endtask

    function automatic logic [23:0] rand_mag();
        case ($urandom_range(0, 4))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 8191)) - 4096);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic drain();
        in_ch.valid <= 0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_regs(int kind);
        write_reg(REG_SCALE_X, kind == 0 ? 48'(SCALE_ONE) : 48'($urandom_range(8192, 32768)));
        write_reg(REG_SCALE_Y, kind == 1 ? 48'hFFFF : 48'($urandom_range(1, 65535)));
        write_reg(REG_SCALE_Z, kind == 2 ? 48'h0 : 48'($urandom()));
        write_reg(REG_BIAS_X, 48'({$urandom(), $urandom()}));
        write_reg(REG_BIAS_Y, 48'($signed($urandom_range(0, 200000)) - 100000));
        write_reg(REG_BIAS_Z, 48'({$urandom(), $urandom()}));
        write_reg(REG_SKEW, 48'({$urandom(), $urandom()}));
    endtask

    initial begin
        bit burst;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // pass-through at reset values, field extremes
        send_sample(24'h7FFFFF, 24'h800000, 24'h000000, 0);
        send_sample(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 0);
        send_sample(24'h000001, 24'h000000, 24'h7FFFFF, 0);
        drain();

        // all scales zero: forced extremes, zero difference counts as positive
        write_reg(REG_SCALE_X, 48'h0);
        write_reg(REG_SCALE_Y, 48'h0);
        write_reg(REG_SCALE_Z, 48'h0);
        write_reg(REG_BIAS_X, 48'h000100);
        send_sample(24'h000100, 24'h800000, 24'h000000, 0);
        send_sample(24'h0000FF, 24'h7FFFFF, 24'hFFFFFF, 0);
        drain();

        // smallest and largest scales, largest angles: heavy clipping; bits above width ignored
        write_reg(REG_SCALE_X, 48'hFFFF_0001);
        write_reg(REG_SCALE_Y, 48'hFFFF);
        write_reg(REG_SCALE_Z, 48'h1);
        write_reg(REG_BIAS_X, 48'hFF_800000);
        write_reg(REG_BIAS_Y, 48'h7FFFFF);
        write_reg(REG_BIAS_Z, 48'h0);
        write_reg(REG_SKEW, 48'h8000_7FFF_8000);
        send_sample(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0);
        send_sample(24'h800000, 24'h7FFFFF, 24'h800000, 0);
        send_sample(24'h000000, 24'h000000, 24'h000000, 0);
        send_sample(24'h123456, 24'hABCDEF, 24'h0F0F0F, 0);
        drain();

        // unit scales with angles only, small fields: rounding ties
        write_reg(REG_SCALE_X, 48'(SCALE_ONE));
        write_reg(REG_SCALE_Y, 48'(SCALE_ONE));
        write_reg(REG_SCALE_Z, 48'(SCALE_ONE));
        write_reg(REG_BIAS_X, 48'h0);
        write_reg(REG_BIAS_Y, 48'h0);
        write_reg(REG_SKEW, 48'h4000_4000_4000);
        send_sample(24'h000001, 24'h000001, 24'h000001, 0);
        send_sample(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0);
        send_sample(24'h000003, 24'hFFFFFD, 24'h000002, 0);
        drain();
        write_reg(REG_SKEW, 48'h0);

        // random phases under varied settings
        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6) begin
                write_reg(REG_SCALE_X, 48'(SCALE_ONE));
                write_reg(REG_SCALE_Y, 48'(SCALE_ONE));
                write_reg(REG_SCALE_Z, 48'(SCALE_ONE));
                write_reg(REG_BIAS_X, 48'h0);
                write_reg(REG_BIAS_Y, 48'h0);
                write_reg(REG_BIAS_Z, 48'h0);
                write_reg(REG_SKEW, 48'h0);
            end else begin
                random_regs(ph % 4);
            end
            if (ph == 2) long_hold = 1;
            for (int k = 0; k < 250; k++) begin
                burst = (ph == 2) || ($urandom_range(0, 7) == 0);
                send_sample(rand_mag(), rand_mag(), rand_mag(), burst);
            end
            drain();
        end

        $display("sent %0d samples over reset, zero-scale, clipping, skew and random settings",
                 sent_cnt);
        $display("checked %0d results", result_cnt);
        if (fail_cnt == 0 && pending == 0) begin
            $display("magnetometer_calibration_correct: match");
        end else begin
            $display("magnetometer_calibration_correct: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/mcc_pkg.sv
hdl/mcc_in_if.sv
hdl/mcc_out_if.sv
hdl/mcc_div.sv
hdl/mcc_skew.sv
hdl/magnetometer_calibration_correct.sv
verif/mcc_checker.sv
verif/magnetometer_calibration_correct_tb.sv
